FILE: hw/rtl/lisp_token_scanner_top_macros.svh
// Assertion macros for the token scanner; empty when synthesizing.
`ifndef LISP_TOKEN_SCANNER_TOP_MACROS_SVH
`define LISP_TOKEN_SCANNER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LTS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define LTS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define LTS_ASSERT_IMP(label, ante, cons)
`define LTS_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: hw/rtl/lts_pkg.sv
// Shared constants, types and character classes of the token scanner.
`default_nettype none

package lts_pkg;

  localparam int MAX_SYMBOL   = 32;
  localparam int NUMBER_WIDTH = 32;
  localparam int SYM_IDX_W    = $clog2(MAX_SYMBOL);
  localparam int SYM_LEN_W    = $clog2(MAX_SYMBOL + 1);
  localparam int NUM_EXT_W    = NUMBER_WIDTH + 4;

  typedef logic [7:0]              byte_t;
  typedef logic [2:0]              kind_t;
  typedef logic [1:0]              mode_t;
  typedef logic [NUMBER_WIDTH-1:0] num_t;

  localparam kind_t TOK_END    = 3'd0;
  localparam kind_t TOK_LPAREN = 3'd1;
  localparam kind_t TOK_RPAREN = 3'd2;
  localparam kind_t TOK_QUOTE  = 3'd3;
  localparam kind_t TOK_NUMBER = 3'd4;
  localparam kind_t TOK_SYMBOL = 3'd5;
  localparam kind_t TOK_TRUE   = 3'd6;
  localparam kind_t TOK_NIL    = 3'd7;

  localparam mode_t MODE_IDLE = 2'd0;
  localparam mode_t MODE_NUM  = 2'd1;
  localparam mode_t MODE_SYM  = 2'd2;

  localparam num_t NUM_MAX = '1;

  localparam byte_t CH_NL     = 8'h0A;
  localparam byte_t CH_QUOTE  = 8'h27;
  localparam byte_t CH_LPAREN = 8'h28;
  localparam byte_t CH_RPAREN = 8'h29;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_NINE   = 8'h39;
  localparam byte_t CH_T      = 8'h54;
  localparam byte_t CH_N      = 8'h4E;
  localparam byte_t CH_I      = 8'h49;
  localparam byte_t CH_L      = 8'h4C;

  typedef struct packed {
    logic latch;
    logic step;
    logic sel_held;
    logic emit_flush;
    logic emit_scan;
    logic advance;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  absorb_now;
    logic  flush_done;
    logic  has_tok;
    logic  held_eoi;
    logic  out_free;
  } dp_sts_t;

  function automatic logic is_digit(input byte_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_alpha(input byte_t c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  // ~ ! @ # $ % ^ & * _ + ` - = < > ? , . /
  function automatic logic is_punct(input byte_t c);
    logic hit;
    case (c) inside
      8'h7E, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h5F,
      8'h2B, 8'h60, 8'h2D, 8'h3D, 8'h3C, 8'h3E, 8'h3F, 8'h2C, 8'h2E,
      8'h2F:   hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_sym_start(input byte_t c);
    return is_alpha(c) || is_punct(c);
  endfunction

  function automatic logic is_sym_cont(input byte_t c);
    return is_alpha(c) || is_punct(c) || is_digit(c);
  endfunction

  function automatic byte_t to_upper(input byte_t c);
    return ((c >= 8'h61) && (c <= 8'h7A)) ? byte_t'(c - 8'h20) : c;
  endfunction

  function automatic logic is_scan_tok(input byte_t c);
    return (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_QUOTE);
  endfunction

  function automatic kind_t scan_kind(input byte_t c);
    kind_t k;
    case (c)
      CH_LPAREN: k = TOK_LPAREN;
      CH_RPAREN: k = TOK_RPAREN;
      default:   k = TOK_QUOTE;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lts_if.sv
// Valid/ready channel interfaces for input bytes and result tokens.
`default_nettype none

interface lts_in_if;
  import lts_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface lts_out_if;
  import lts_pkg::*;
  logic        valid;
  logic        ready;
  kind_t       token_kind;
  logic [31:0] number_value;
  byte_t       symbol_char;
  logic        symbol_end;
  logic        too_long;
  logic [31:0] line_number;
  logic        last_of_run;

  modport source (output valid, output token_kind, output number_value,
                  output symbol_char, output symbol_end, output too_long,
                  output line_number, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input symbol_char, input symbol_end, input too_long,
                  input line_number, input last_of_run, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lts_ctrl.sv
// Controller state machine: accept, flush pending token, scan held byte.
`default_nettype none

module lts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lts_pkg::dp_sts_t  sts,
  output lts_pkg::dp_cmd_t  cmd
);
  import lts_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (sts.absorb_now) begin
            cmd.step = 1'b1;
          end else if (sts.mode != MODE_IDLE) begin
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_flush = 1'b1;
          if (sts.flush_done) begin
            cmd.clear = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (!sts.has_tok || sts.out_free) begin
          cmd.emit_scan = sts.has_tok;
          cmd.step      = !sts.held_eoi;
          cmd.sel_held  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lts_datapath.sv
// Datapath: scan state, number accumulator, symbol buffer, result register.
`default_nettype none

module lts_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lts_pkg::byte_t    in_byte,
  input  logic              end_of_input,
  input  lts_pkg::dp_cmd_t  cmd,
  output lts_pkg::dp_sts_t  sts,
  input  logic              out_ready,
  output logic              out_valid,
  output lts_pkg::kind_t    token_kind,
  output logic [31:0]       number_value,
  output lts_pkg::byte_t    symbol_char,
  output logic              symbol_end,
  output logic              too_long,
  output logic [31:0]       line_number,
  output logic              last_of_run
);
  import lts_pkg::*;

  mode_t                mode_r, mode_nxt;
  num_t                 acc_r, acc_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [SYM_LEN_W-1:0] len_r, len_nxt;
  logic [31:0]          line_r, line_nxt;
  logic [SYM_IDX_W-1:0] idx_r, idx_nxt;
  logic                 kw_t_r, kw_t_nxt;
  logic                 kw_n_r, kw_n_nxt;
  logic                 kw_i_r, kw_i_nxt;
  logic                 kw_l_r, kw_l_nxt;
  byte_t                held_byte_r;
  logic                 held_eoi_r;

  byte_t                mem [MAX_SYMBOL];
  byte_t                rd_data_r;
  logic                 wr_en;
  logic [SYM_IDX_W-1:0] wr_addr;
  byte_t                wr_data;

  logic                 out_valid_r, out_valid_nxt;
  kind_t                kind_r, kind_nxt;
  logic [31:0]          value_r, value_nxt;
  byte_t                char_r, char_nxt;
  logic                 send_r, send_nxt;
  logic                 tl_r, tl_nxt;
  logic [31:0]          oline_r;
  logic                 last_r, last_nxt;

  byte_t                src;
  byte_t                up;
  logic [NUM_EXT_W-1:0] acc_ext;
  logic [NUM_EXT_W-1:0] num_ext;
  logic                 num_over;
  logic                 kw_t;
  logic                 kw_nil;
  logic [SYM_LEN_W-1:0] idx_ext;
  logic                 sym_last;
  logic                 out_free;
  logic                 emit;

  assign src      = cmd.sel_held ? held_byte_r : in_byte;
  assign up       = to_upper(src);
  assign acc_ext  = NUM_EXT_W'(acc_r);
  assign num_ext  = (acc_ext << 3) + (acc_ext << 1) + NUM_EXT_W'(src[3:0]);
  assign num_over = ovf_r || (|num_ext[NUM_EXT_W-1:NUMBER_WIDTH]);
  assign kw_t     = !ovf_r && (len_r == SYM_LEN_W'(1)) && kw_t_r;
  assign kw_nil   = !ovf_r && (len_r == SYM_LEN_W'(3)) && kw_n_r && kw_i_r && kw_l_r;
  assign idx_ext  = SYM_LEN_W'(idx_r);
  assign sym_last = (idx_ext + SYM_LEN_W'(1)) == len_r;
  assign out_free = !out_valid_r || out_ready;
  assign emit     = cmd.emit_flush || cmd.emit_scan;

  always_comb begin
    sts            = '0;
    sts.mode       = mode_r;
    sts.absorb_now = !end_of_input &&
                     (((mode_r == MODE_NUM) && is_digit(in_byte)) ||
                      ((mode_r == MODE_SYM) && is_sym_cont(in_byte)) ||
                      ((mode_r == MODE_IDLE) && !is_scan_tok(in_byte)));
    sts.flush_done = (mode_r != MODE_SYM) || kw_t || kw_nil || sym_last;
    sts.has_tok    = held_eoi_r || is_scan_tok(held_byte_r);
    sts.held_eoi   = held_eoi_r;
    sts.out_free   = out_free;
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    len_nxt  = len_r;
    line_nxt = line_r;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = up;
    if (cmd.step) begin
      unique case (mode_r)
        MODE_NUM: begin
          if (is_digit(src)) begin
            if (num_over) begin
              acc_nxt = NUM_MAX;
              ovf_nxt = 1'b1;
            end else begin
              acc_nxt = num_ext[NUMBER_WIDTH-1:0];
            end
          end
        end
        MODE_SYM: begin
          if (is_sym_cont(src)) begin
            if (len_r < SYM_LEN_W'(MAX_SYMBOL)) begin
              wr_en   = 1'b1;
              wr_addr = len_r[SYM_IDX_W-1:0];
              len_nxt = len_r + SYM_LEN_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end
        MODE_IDLE: begin
          if (src == CH_NL) begin
            line_nxt = line_r + 32'd1;
          end else if (is_digit(src)) begin
            mode_nxt = MODE_NUM;
            acc_nxt  = NUMBER_WIDTH'(src[3:0]);
            ovf_nxt  = 1'b0;
          end else if (is_sym_start(src)) begin
            mode_nxt = MODE_SYM;
            wr_en    = 1'b1;
            len_nxt  = SYM_LEN_W'(1);
            ovf_nxt  = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.clear) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;
      len_nxt  = '0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clear) begin
      idx_nxt = '0;
    end else if (cmd.advance) begin
      idx_nxt = idx_r + SYM_IDX_W'(1);
    end
  end

  always_comb begin
    kw_t_nxt = kw_t_r;
    kw_n_nxt = kw_n_r;
    kw_i_nxt = kw_i_r;
    kw_l_nxt = kw_l_r;
    if (wr_en) begin
      if (wr_addr == SYM_IDX_W'(0)) begin
        kw_t_nxt = (wr_data == CH_T);
        kw_n_nxt = (wr_data == CH_N);
      end
      if (wr_addr == SYM_IDX_W'(1)) begin
        kw_i_nxt = (wr_data == CH_I);
      end
      if (wr_addr == SYM_IDX_W'(2)) begin
        kw_l_nxt = (wr_data == CH_L);
      end
    end
  end

  always_comb begin
    kind_nxt  = TOK_END;
    value_nxt = '0;
    char_nxt  = '0;
    send_nxt  = 1'b0;
    tl_nxt    = 1'b0;
    last_nxt  = 1'b1;
    if (cmd.emit_flush) begin
      last_nxt = !sts.has_tok;
      if (mode_r == MODE_NUM) begin
        kind_nxt  = TOK_NUMBER;
        value_nxt = 32'(acc_r);
        tl_nxt    = ovf_r;
      end else if (kw_t) begin
        kind_nxt = TOK_TRUE;
      end else if (kw_nil) begin
        kind_nxt = TOK_NIL;
      end else begin
        kind_nxt = TOK_SYMBOL;
        char_nxt = rd_data_r;
        send_nxt = sym_last;
        tl_nxt   = ovf_r;
        last_nxt = sym_last && !sts.has_tok;
      end
    end else if (!held_eoi_r) begin
      kind_nxt = scan_kind(held_byte_r);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      acc_r       <= '0;
      ovf_r       <= 1'b0;
      len_r       <= '0;
      line_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      acc_r       <= acc_nxt;
      ovf_r       <= ovf_nxt;
      len_r       <= len_nxt;
      line_r      <= line_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kw_t_r <= kw_t_nxt;
    kw_n_r <= kw_n_nxt;
    kw_i_r <= kw_i_nxt;
    kw_l_r <= kw_l_nxt;
    if (cmd.latch) begin
      held_byte_r <= in_byte;
      held_eoi_r  <= end_of_input;
    end
    if (emit) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      char_r  <= char_nxt;
      send_r  <= send_nxt;
      tl_r    <= tl_nxt;
      oline_r <= line_r;
      last_r  <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign token_kind   = kind_r;
  assign number_value = value_r;
  assign symbol_char  = char_r;
  assign symbol_end   = send_r;
  assign too_long     = tl_r;
  assign line_number  = oline_r;
  assign last_of_run  = last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/lisp_token_scanner_top.sv
// Top level of the Lisp token scanner: controller, datapath and channels.
//
//   channel  dir  handshake       payload
//   in_ch    in   valid / ready   in_byte, end_of_input
//   out_ch   out  valid / ready   token_kind, number_value, symbol_char,
//                                 symbol_end, too_long, line_number, last_of_run
//
// A byte that continues a number or symbol, or causes no token, is absorbed.
// A byte that ends a token, or is a parenthesis, quote or end of input, is held;
// flush emits a pending number, T or NIL, or a symbol at one buffer read per
// cycle while the output is free; scan then emits any token of the held byte.
// Reset is synchronous; no clearing pass, the symbol buffer is read only below
// its fill length. A stalled result register holds the flush in place; input
// is taken only between items and may be taken while a result still waits.
`default_nettype none

`include "lisp_token_scanner_top_macros.svh"

module lisp_token_scanner_top (
  input  logic      clk,
  input  logic      rst_n,
  lts_in_if.sink    in_ch,
  lts_out_if.source out_ch
);
  import lts_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  lts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lts_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .token_kind   (out_ch.token_kind),
    .number_value (out_ch.number_value),
    .symbol_char  (out_ch.symbol_char),
    .symbol_end   (out_ch.symbol_end),
    .too_long     (out_ch.too_long),
    .line_number  (out_ch.line_number),
    .last_of_run  (out_ch.last_of_run)
  );

  assign in_ch.ready = in_ready;

  `LTS_ASSERT_IMP(a_end_is_last, out_ch.valid && (out_ch.token_kind == TOK_END), out_ch.last_of_run)
  `LTS_ASSERT_IMP(a_symend_kind, out_ch.valid && out_ch.symbol_end, out_ch.token_kind == TOK_SYMBOL)
  `LTS_ASSERT_NXT(a_busy_after_tok, in_ch.valid && in_ch.ready && !sts.absorb_now, !in_ch.ready)

endmodule

`default_nettype wire
